### hw/rtl/mrsc_pkg.sv
package mrsc_pkg;

  localparam int IN_N   = 3;
  localparam int HID_N  = 2;
  localparam int OUT_N  = 5;

  localparam int X_W    = 16;
  localparam int PROB_W = 16;
  localparam int CLS_W  = 3;
  localparam int WT_W   = 16;

  // Hidden products and sums, Q.22, below 2^31 in magnitude.
  localparam int HP_W   = 32;
  // Hidden value after ReLU, Q.12.
  localparam int H_W    = 21;
  // Logits, Q.22.
  localparam int Z_W    = 38;
  localparam int D_W    = Z_W + 1;
  localparam int E_W    = 17;
  localparam int SUM_W  = E_W + $clog2(OUT_N);
  localparam int Q_W    = 17;
  localparam int REM_W  = SUM_W + Q_W;

  // Bit positions inside the logit difference d: t = d >> 14,
  // i = t >> 8, a = t[7:4], b = t[3:0].
  localparam int T_LSB  = 14;
  localparam int I_LSB  = T_LSB + 8;
  localparam int I_MSB  = I_LSB + 3;

  typedef logic signed [X_W-1:0] accel_t;
  typedef logic [PROB_W-1:0]     prob_t;
  typedef logic [CLS_W-1:0]      cls_t;
  typedef logic signed [WT_W-1:0] wt_t;

  localparam wt_t W_IN [IN_N][HID_N] = '{
    '{16'sd989,   -16'sd4858},
    '{-16'sd7024, -16'sd4542},
    '{16'sd865,   16'sd2562}
  };
  localparam wt_t B_HID [HID_N] = '{16'sd3242, 16'sd3600};
  localparam wt_t W_OUT [HID_N][OUT_N] = '{
    '{-16'sd17275, -16'sd7073, 16'sd1932, 16'sd6536, -16'sd2827},
    '{16'sd6547, -16'sd3411, -16'sd1372, -16'sd10881, 16'sd2810}
  };
  localparam wt_t B_OUT [OUT_N] =
    '{-16'sd11267, 16'sd6300, -16'sd12366, -16'sd11864, -16'sd2946};

  // exp(-i) for integer i; the entries past eleven are zero so that a
  // large difference gives a zero exponential through the same path.
  localparam logic [E_W-1:0] EXP_INT [16] = '{
    17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
    17'd22, 17'd8, 17'd3, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0
  };
  localparam logic [E_W-1:0] EXP_HI [16] = '{
    17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947, 17'd45042,
    17'd42313, 17'd39750, 17'd37341, 17'd35079, 17'd32954, 17'd30957, 17'd29081,
    17'd27319, 17'd25664
  };
  localparam logic [E_W-1:0] EXP_LO [16] = '{
    17'd65536, 17'd65280, 17'd65026, 17'd64772, 17'd64520, 17'd64268, 17'd64018,
    17'd63768, 17'd63520, 17'd63272, 17'd63025, 17'd62780, 17'd62535, 17'd62291,
    17'd62048, 17'd61806
  };

endpackage

### hw/rtl/mrsc_if.sv
interface mrsc_in_if;
  import mrsc_pkg::*;
  logic   valid;
  logic   ready;
  accel_t accel_x;
  accel_t accel_y;
  accel_t accel_z;
  modport source (output valid, output accel_x, output accel_y, output accel_z,
                  input ready);
  modport sink (input valid, input accel_x, input accel_y, input accel_z,
                output ready);
endinterface

interface mrsc_out_if;
  import mrsc_pkg::*;
  logic  valid;
  logic  ready;
  prob_t prob_0;
  prob_t prob_1;
  prob_t prob_2;
  prob_t prob_3;
  prob_t prob_4;
  cls_t  best_class;
  modport source (output valid, output prob_0, output prob_1, output prob_2,
                  output prob_3, output prob_4, output best_class, input ready);
  modport sink (input valid, input prob_0, input prob_1, input prob_2,
                input prob_3, input prob_4, input best_class, output ready);
endinterface

### hw/rtl/mlp_relu_softmax_classifier.sv
// Channel   Direction  Contents
// in_s      in         accel_x, accel_y, accel_z (signed Q4.12)
// out_m     out        prob_0..prob_4 (unsigned Q0.16), best_class
//
// One sample enters every cycle while the output is not stalled. A result
// passes through nine arithmetic stages, the division setup, seventeen quotient
// stages (one bit each) and the output register. The long division sets
// most of that depth. Reset clears only the valid bits. A stall at the output
// freezes every stage at once, so nothing is lost or repeated.
module mlp_relu_softmax_classifier (
  input logic clk,
  input logic rst_n,
  mrsc_in_if.sink    in_s,
  mrsc_out_if.source out_m
);
  import mrsc_pkg::*;

  // The whole pipeline advances together whenever the output register is
  // empty or its result is taken in this cycle.
  logic adv;

  // Stage 1: input weight products.
  logic                    s1_v_r;
  logic signed [HP_W-1:0]  hp_r   [IN_N][HID_N];
  logic signed [HP_W-1:0]  hp_nxt [IN_N][HID_N];
  // Stage 2: hidden values after ReLU.
  logic                    s2_v_r;
  logic [H_W-1:0]          h_r    [HID_N];
  logic [H_W-1:0]          h_nxt  [HID_N];
  // Stage 3: layer weight products.
  logic                    s3_v_r;
  logic signed [Z_W-1:0]   op_r   [HID_N][OUT_N];
  logic signed [Z_W-1:0]   op_nxt [HID_N][OUT_N];
  // Stage 4: logits.
  logic                    s4_v_r;
  logic signed [Z_W-1:0]   z_r    [OUT_N];
  logic signed [Z_W-1:0]   z_nxt  [OUT_N];
  // Stage 5: largest logit and its index.
  logic                    s5_v_r;
  logic signed [Z_W-1:0]   z5_r   [OUT_N];
  logic signed [Z_W-1:0]   zmax_r, zmax_nxt;
  cls_t                    best5_r, best5_nxt;
  // Stage 6: exp table indexes.
  logic                    s6_v_r;
  logic [3:0]              ei_r   [OUT_N];
  logic [3:0]              ei_nxt [OUT_N];
  logic [7:0]              t_r    [OUT_N];
  logic [7:0]              t_nxt  [OUT_N];
  cls_t                    best6_r;
  // Stage 7: first table product.
  logic                    s7_v_r;
  logic [E_W-1:0]          p_r    [OUT_N];
  logic [E_W-1:0]          p_nxt  [OUT_N];
  logic [3:0]              lo_r   [OUT_N];
  cls_t                    best7_r;
  // Stage 8: exponentials.
  logic                    s8_v_r;
  logic [E_W-1:0]          e_r    [OUT_N];
  logic [E_W-1:0]          e_nxt  [OUT_N];
  cls_t                    best8_r;
  // Stage 9: their sum.
  logic                    s9_v_r;
  logic [E_W-1:0]          e9_r   [OUT_N];
  logic [SUM_W-1:0]        sum_r, sum_nxt;
  cls_t                    best9_r;
  // Division stages: entry 0 holds the rounded numerators, entry k holds
  // the partial remainders after k quotient bits.
  logic                    dv_v_r    [Q_W+1];
  logic [REM_W-1:0]        rem_r     [Q_W+1][OUT_N];
  logic [REM_W-1:0]        rem_nxt   [Q_W+1][OUT_N];
  logic [Q_W-1:0]          q_r       [Q_W+1][OUT_N];
  logic [Q_W-1:0]          q_nxt     [Q_W+1][OUT_N];
  logic [SUM_W-1:0]        dsum_r    [Q_W+1];
  cls_t                    dbest_r   [Q_W+1];
  // Output register.
  logic                    o_v_r;
  prob_t                   prob_r    [OUT_N];
  prob_t                   prob_nxt  [OUT_N];
  cls_t                    cls_r;

  assign adv        = !o_v_r || out_m.ready;
  assign in_s.ready = adv;

  always_comb begin
    accel_t                 x [IN_N];
    logic signed [HP_W-1:0] hacc;
    logic [D_W-1:0]         d;
    logic [2*E_W:0]         m;
    logic [REM_W-1:0]       dvs;
    int                     bitpos;
    x[0] = in_s.accel_x;
    x[1] = in_s.accel_y;
    x[2] = in_s.accel_z;
    for (int j = 0; j < IN_N; j++) begin
      for (int i = 0; i < HID_N; i++) begin
        hp_nxt[j][i] = HP_W'(W_IN[j][i]) * HP_W'(x[j]);
      end
    end
    // Bias is Q.10; scaled by 4096 to meet the Q.22 products.
    for (int i = 0; i < HID_N; i++) begin
      hacc = HP_W'(B_HID[i]) <<< 12;
      for (int j = 0; j < IN_N; j++) begin
        hacc = hacc + hp_r[j][i];
      end
      h_nxt[i] = hacc[HP_W-1] ? '0 : hacc[H_W+9:10];
    end
    for (int j = 0; j < HID_N; j++) begin
      for (int i = 0; i < OUT_N; i++) begin
        op_nxt[j][i] = Z_W'(W_OUT[j][i]) * Z_W'(signed'({1'b0, h_r[j]}));
      end
    end
    for (int i = 0; i < OUT_N; i++) begin
      z_nxt[i] = Z_W'(B_OUT[i]) <<< 12;
      for (int j = 0; j < HID_N; j++) begin
        z_nxt[i] = z_nxt[i] + op_r[j][i];
      end
    end
    // Strict compare keeps the lowest index on ties.
    zmax_nxt  = z_r[0];
    best5_nxt = '0;
    for (int i = 1; i < OUT_N; i++) begin
      if (z_r[i] > zmax_nxt) begin
        zmax_nxt  = z_r[i];
        best5_nxt = CLS_W'(i);
      end
    end
    // A difference of twelve or more in the integer part points at a zero
    // entry of the integer table.
    for (int i = 0; i < OUT_N; i++) begin
      d = D_W'(zmax_r) - D_W'(z5_r[i]);
      ei_nxt[i] = (|d[D_W-1:I_MSB+1] || (d[I_MSB:I_LSB] >= 4'd12)) ?
                  4'd12 : d[I_MSB:I_LSB];
      t_nxt[i]  = d[I_LSB-1:T_LSB];
    end
    for (int i = 0; i < OUT_N; i++) begin
      m = (2*E_W+1)'(EXP_INT[ei_r[i]]) * (2*E_W+1)'(EXP_HI[t_r[i][7:4]]) +
          (2*E_W+1)'(32768);
      p_nxt[i] = m[E_W+15:16];
    end
    for (int i = 0; i < OUT_N; i++) begin
      m = (2*E_W+1)'(p_r[i]) * (2*E_W+1)'(EXP_LO[lo_r[i]]) + (2*E_W+1)'(32768);
      e_nxt[i] = m[E_W+15:16];
    end
    sum_nxt = '0;
    for (int i = 0; i < OUT_N; i++) begin
      sum_nxt = sum_nxt + SUM_W'(e_r[i]);
    end
    // Numerator e * 65536 + S / 2, then one quotient bit per stage.
    for (int i = 0; i < OUT_N; i++) begin
      rem_nxt[0][i] = (REM_W'(e9_r[i]) << PROB_W) + REM_W'(sum_r >> 1);
      q_nxt[0][i]   = '0;
    end
    for (int k = 0; k < Q_W; k++) begin
      bitpos = Q_W - 1 - k;
      dvs    = REM_W'(dsum_r[k]) << bitpos;
      for (int i = 0; i < OUT_N; i++) begin
        rem_nxt[k+1][i] = rem_r[k][i];
        q_nxt[k+1][i]   = q_r[k][i];
        if (rem_r[k][i] >= dvs) begin
          rem_nxt[k+1][i]       = rem_r[k][i] - dvs;
          q_nxt[k+1][i][bitpos] = 1'b1;
        end
      end
    end
    // The winning class alone yields exactly 1.0, which saturates.
    for (int i = 0; i < OUT_N; i++) begin
      prob_nxt[i] = q_r[Q_W][i][Q_W-1] ? '1 : q_r[Q_W][i][PROB_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
      s9_v_r <= 1'b0;
      for (int k = 0; k <= Q_W; k++) begin
        dv_v_r[k] <= 1'b0;
      end
      o_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r    <= in_s.valid;
      s2_v_r    <= s1_v_r;
      s3_v_r    <= s2_v_r;
      s4_v_r    <= s3_v_r;
      s5_v_r    <= s4_v_r;
      s6_v_r    <= s5_v_r;
      s7_v_r    <= s6_v_r;
      s8_v_r    <= s7_v_r;
      s9_v_r    <= s8_v_r;
      dv_v_r[0] <= s9_v_r;
      for (int k = 0; k < Q_W; k++) begin
        dv_v_r[k+1] <= dv_v_r[k];
      end
      o_v_r <= dv_v_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hp_r    <= hp_nxt;
      h_r     <= h_nxt;
      op_r    <= op_nxt;
      z_r     <= z_nxt;
      z5_r    <= z_r;
      zmax_r  <= zmax_nxt;
      best5_r <= best5_nxt;
      ei_r    <= ei_nxt;
      t_r     <= t_nxt;
      best6_r <= best5_r;
      p_r     <= p_nxt;
      for (int i = 0; i < OUT_N; i++) begin
        lo_r[i] <= t_r[i][3:0];
      end
      best7_r    <= best6_r;
      e_r        <= e_nxt;
      best8_r    <= best7_r;
      e9_r       <= e_r;
      sum_r      <= sum_nxt;
      best9_r    <= best8_r;
      rem_r      <= rem_nxt;
      q_r        <= q_nxt;
      dsum_r[0]  <= sum_r;
      dbest_r[0] <= best9_r;
      for (int k = 0; k < Q_W; k++) begin
        dsum_r[k+1]  <= dsum_r[k];
        dbest_r[k+1] <= dbest_r[k];
      end
      prob_r <= prob_nxt;
      cls_r  <= dbest_r[Q_W];
    end
  end

  assign out_m.valid      = o_v_r;
  assign out_m.prob_0     = prob_r[0];
  assign out_m.prob_1     = prob_r[1];
  assign out_m.prob_2     = prob_r[2];
  assign out_m.prob_3     = prob_r[3];
  assign out_m.prob_4     = prob_r[4];
  assign out_m.best_class = cls_r;

endmodule
